@@ sv/fpd_pkg.sv @@
package fpd_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF = 32;

  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTORTION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd5;

  localparam logic [15:0] ZOOM_ONE = 16'd256;
  localparam logic [15:0] K_RESET  = 16'd256;

endpackage

@@ sv/fpd_point_mem.sv @@
module fpd_point_mem import fpd_pkg::*; #(
  parameter int unsigned DEPTH = MAX_POINTS_DEF,
  parameter int unsigned WIDTH = 3 * COORD_BITS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fpd_sqrt.sv @@
module fpd_sqrt import fpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q, v_d, r_q, r_d, b_q, b_d, trial;
  logic        run_q, run_d, done_q, done_d;

  // one result bit per cycle
  always_comb begin
    trial  = r_q + b_q;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d   = rad_i;
      r_d   = '0;
      b_d   = 64'h4000_0000_0000_0000;
      run_d = 1'b1;
    end else if (run_q) begin
      if (v_q >= trial) begin
        v_d = v_q - trial;
        r_d = (r_q >> 1) + b_q;
      end else begin
        r_d = r_q >> 1;
      end
      b_d = b_q >> 2;
      if (b_q == 64'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    r_q <= r_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

@@ sv/fpd_div.sv @@
module fpd_div import fpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0] n_q, n_d, rem_q, rem_d, den_q, den_d, sh;
  logic [6:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    sh     = {rem_q[62:0], n_q[63]};
    n_d    = n_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      n_d   = dividend_i;
      den_d = divisor_i;
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (sh >= den_q) begin
        rem_d = sh - den_q;
        n_d   = {n_q[62:0], 1'b1};
      end else begin
        rem_d = sh;
        n_d   = {n_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

@@ sv/fisheye_point_distortion.sv @@
// Fisheye point distortion. Points are loaded one per cycle while busy_o is low
// (start_i high); a point that carries is_last_point_i starts emission and busy_o
// rises. Emission makes two passes over the point memory: the first finds the
// largest inside distance (inside points go through the 32-step square root),
// the second emits each point in load order (an inside point goes through the
// square root and, if its distance is not zero, the 64-step divider; an outside
// point skips both). Each result shows for one cycle on result_valid_o and must
// be taken then: the receiver cannot stall. Configuration must be written only
// while busy_o is low; the block does not enforce this. Its port is always ready.
module fisheye_point_distortion import fpd_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [31:0]   point_x_i,
  input  logic signed [31:0]   point_y_i,
  input  logic signed [31:0]   point_z_i,
  input  logic                 is_last_point_i,
  output logic                 result_valid_o,
  output logic signed [31:0]   warped_x_o,
  output logic signed [31:0]   warped_y_o,
  output logic signed [31:0]   warped_z_o,
  output logic [15:0]          zoom_o,
  output logic                 was_inside_o,
  output logic                 is_last_result_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DIFF = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_ND   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_WP   = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  // configuration
  logic [31:0] fx_q, fy_q, fz_q;
  logic [30:0] rad_q;
  logic [15:0] kf_q;
  logic        sph_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q  <= '0;
      fy_q  <= '0;
      fz_q  <= '0;
      rad_q <= '0;
      kf_q  <= K_RESET;
      sph_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FOCUS_X:    fx_q  <= cfg_data_i;
        CFG_FOCUS_Y:    fy_q  <= cfg_data_i;
        CFG_FOCUS_Z:    fz_q  <= cfg_data_i;
        CFG_RADIUS:     rad_q <= cfg_data_i[30:0];
        CFG_DISTORTION: kf_q  <= cfg_data_i[15:0];
        CFG_MODE:       sph_q <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // control state
  logic [3:0]    state_q;
  logic [CW-1:0] cnt_q, n_q, idx_q, idx_nx;
  logic          pass_q;
  logic [30:0]   rmax_q;
  logic [2:0]    step_q;

  // point memory
  logic            mem_we, mem_re, full;
  logic [3*CB-1:0] mem_wdata, mem_rdata;
  logic [CB-1:0]   px, py, pz;

  assign full      = (cnt_q >= CW'(MAX_POINTS));
  assign mem_we    = start_i && !busy_o && !full;
  assign mem_re    = (state_q == S_RD);
  assign mem_wdata = {CB'($unsigned(point_z_i)), CB'($unsigned(point_y_i)),
                      CB'($unsigned(point_x_i))};
  assign px        = mem_rdata[CB-1:0];
  assign py        = mem_rdata[2*CB-1:CB];
  assign pz        = mem_rdata[3*CB-1:2*CB];

  fpd_point_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (3 * CB),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  // differences from the focus
  logic [CB-1:0]      fxc, fyc, fzc;
  logic signed [CB:0] dx, dy, dz;
  logic [CB:0]        mx, my, mz;
  logic               inb;

  assign fxc = CB'(fx_q);
  assign fyc = CB'(fy_q);
  assign fzc = CB'(fz_q);
  assign dx  = signed'({px[CB-1], px}) - signed'({fxc[CB-1], fxc});
  assign dy  = signed'({py[CB-1], py}) - signed'({fyc[CB-1], fyc});
  assign dz  = sph_q ? (signed'({pz[CB-1], pz}) - signed'({fzc[CB-1], fzc})) : '0;
  assign mx  = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
  assign my  = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
  assign mz  = dz[CB] ? $unsigned(-dz) : $unsigned(dz);
  assign inb = (64'(mx) <= 64'(rad_q)) && (64'(my) <= 64'(rad_q)) &&
               (64'(mz) <= 64'(rad_q));

  logic [CB:0]  ax_q, ay_q, az_q;
  logic         nx_q, ny_q, nz_q, inb_q;
  logic [63:0]  acc_q, rr_q, prod_q, num_q;
  logic [30:0]  d_q;
  logic [31:0]  q_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQ: begin
        case (step_q)
          3'd0: begin mul_a = 32'(rad_q); mul_b = 32'(rad_q); end
          3'd1: begin mul_a = 32'(ax_q);  mul_b = 32'(ax_q);  end
          3'd2: begin mul_a = 32'(ay_q);  mul_b = 32'(ay_q);  end
          3'd3: begin mul_a = 32'(az_q);  mul_b = 32'(az_q);  end
          default: ;
        endcase
      end
      S_ND: begin
        if (step_q == 3'd0) begin
          mul_a = 32'(kf_q) + 32'd256;
          mul_b = 32'(rmax_q);
        end else begin
          mul_a = 32'(kf_q);
          mul_b = 32'(d_q);
        end
      end
      S_WP: begin
        mul_b = q_q;
        case (step_q)
          3'd0:    mul_a = 32'(ax_q);
          3'd1:    mul_a = 32'(ay_q);
          default: mul_a = 32'(az_q);
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // iterative units
  logic        in_lens, sq_start, sq_done, dv_start, dv_done;
  logic [31:0] root;
  logic [63:0] quot, den;

  assign in_lens  = inb_q && (acc_q <= rr_q);
  assign sq_start = (state_q == S_CMP) && in_lens;
  assign den      = prod_q + {25'd0, rmax_q, 8'd0};
  assign dv_start = (state_q == S_ND) && (step_q == 3'd2);

  fpd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (acc_q),
    .done_o  (sq_done),
    .root_o  (root)
  );

  fpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i ({num_q[47:0], 16'd0}),
    .divisor_i  (den),
    .done_o     (dv_done),
    .quot_o     (quot)
  );

  function automatic logic [31:0] ext32(logic [CB-1:0] v);
    logic [63:0] e;
    e = {{(64-CB){v[CB-1]}}, v};
    return e[31:0];
  endfunction

  function automatic logic [31:0] warp_fin(logic [CB-1:0] f, logic neg, logic [63:0] p);
    logic [63:0]        m;
    logic signed [63:0] fe, s, hi, lo, r;
    m  = (p + 64'd32768) >> 16;
    fe = signed'({{(64-CB){f[CB-1]}}, f});
    s  = neg ? (fe - signed'(m)) : (fe + signed'(m));
    hi = signed'((64'd1 << (CB - 1)) - 64'd1);
    lo = -hi - 64'sd1;
    r  = (s > hi) ? hi : ((s < lo) ? lo : s);
    return r[31:0];
  endfunction

  logic [63:0] zt;
  assign zt     = (quot + 64'd128) >> 8;
  assign idx_nx = idx_q + CW'(1);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      idx_q   <= '0;
      pass_q  <= 1'b0;
      rmax_q  <= '0;
      step_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (!full) begin
              cnt_q <= cnt_q + CW'(1);
            end
            if (is_last_point_i) begin
              n_q     <= full ? cnt_q : cnt_q + CW'(1);
              idx_q   <= '0;
              pass_q  <= 1'b0;
              rmax_q  <= '0;
              state_q <= S_RD;
            end
          end
        end
        S_RD:   state_q <= S_DIFF;
        S_DIFF: begin
          step_q  <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd4) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (in_lens) begin
            state_q <= S_SQRT;
          end else if (pass_q) begin
            state_q <= S_EMIT;
          end else if (idx_nx == n_q) begin
            pass_q  <= 1'b1;
            idx_q   <= '0;
            state_q <= S_RD;
          end else begin
            idx_q   <= idx_nx;
            state_q <= S_RD;
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            step_q <= '0;
            if (pass_q) begin
              state_q <= (root == 32'd0) ? S_EMIT : S_ND;
            end else begin
              if (root[30:0] > rmax_q) begin
                rmax_q <= root[30:0];
              end
              if (idx_nx == n_q) begin
                pass_q <= 1'b1;
                idx_q  <= '0;
              end else begin
                idx_q <= idx_nx;
              end
              state_q <= S_RD;
            end
          end
        end
        S_ND: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd2) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_done) begin
            step_q  <= '0;
            state_q <= S_WP;
          end
        end
        S_WP: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd3) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (idx_nx == n_q) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q   <= idx_nx;
            state_q <= S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  logic signed [31:0] wx_q, wy_q, wz_q;
  logic [15:0]        zoom_q;
  logic               ins_q, last_q;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_DIFF: begin
        ax_q  <= mx;
        ay_q  <= my;
        az_q  <= mz;
        nx_q  <= dx[CB];
        ny_q  <= dy[CB];
        nz_q  <= dz[CB];
        inb_q <= inb;
        acc_q <= '0;
      end
      S_SQ: begin
        if (step_q != 3'd4) begin
          prod_q <= mul_p;
        end
        if (step_q == 3'd1) begin
          rr_q <= prod_q;
        end else if (step_q >= 3'd2) begin
          acc_q <= acc_q + prod_q;
        end
      end
      S_CMP: begin
        wx_q   <= ext32(px);
        wy_q   <= ext32(py);
        wz_q   <= ext32(pz);
        zoom_q <= ZOOM_ONE;
        ins_q  <= in_lens;
        last_q <= (idx_nx == n_q);
      end
      S_SQRT: begin
        if (sq_done) begin
          d_q <= root[30:0];
        end
      end
      S_ND: begin
        prod_q <= mul_p;
        if (step_q == 3'd1) begin
          num_q <= prod_q;
        end
      end
      S_DIV: begin
        if (dv_done) begin
          q_q    <= quot[31:0];
          zoom_q <= (zt[63:16] != '0) ? 16'hFFFF : zt[15:0];
        end
      end
      S_WP: begin
        if (step_q != 3'd3) begin
          prod_q <= mul_p;
        end
        case (step_q)
          3'd1: wx_q <= warp_fin(fxc, nx_q, prod_q);
          3'd2: wy_q <= warp_fin(fyc, ny_q, prod_q);
          3'd3: begin
            if (sph_q) begin
              wz_q <= warp_fin(fzc, nz_q, prod_q);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign busy_o           = (state_q != S_IDLE);
  assign result_valid_o   = (state_q == S_EMIT);
  assign warped_x_o       = wx_q;
  assign warped_y_o       = wy_q;
  assign warped_z_o       = wz_q;
  assign zoom_o           = zoom_q;
  assign was_inside_o     = ins_q;
  assign is_last_result_o = last_q;

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe while idle");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && is_last_result_o |=> !busy_o && (cnt_q == '0))
    else $error("run did not end after last result");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("point count out of range");

  a_outside_zoom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !was_inside_o |-> zoom_o == ZOOM_ONE)
    else $error("outside point with zoom other than one");

  a_rmax_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> rmax_q <= rad_q)
    else $error("range exceeds lens radius");

endmodule
